@@ design/hsv_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the HSV to RGB converter
// Pixel payload structs, queue entry, sector codes and fixed-point constants.
// ----------------------------------------------------------------------------
package hsv_pkg;

   // Fixed-point formats
   localparam int HUE_FRAC_BITS  = 6;
   localparam int CHAN_FRAC_BITS = 10;
   localparam int CHAN_ONE       = 1 << CHAN_FRAC_BITS;         // 1.0 in Q10
   localparam int HUE_SPAN       = 60 << HUE_FRAC_BITS;         // 60 degrees
   localparam int HUE_TURN       = 6 * HUE_SPAN;                // 360 degrees
   localparam int MID_FULL       = CHAN_ONE * HUE_SPAN;         // ONE*SPAN
   localparam int CHAN_MAX       = 255;
   // SPAN = 256 * 15: the /SPAN step becomes a shift and a divide by 15
   localparam int DIV_SMALL      = HUE_SPAN >> 8;
   localparam int DIV_RECIP      = 65535 / DIV_SMALL;

   // Queue between front and back
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCOUNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic signed [15:0] hue;
      logic [10:0]        saturation;
      logic [10:0]        brightness;
   } hsv_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsv_rsp_type;

   // Sixty-degree sectors, named by the colors at their edges
   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } hsv_sector_type;

   // Classified pixel, as held in the queue
   typedef struct packed {
      hsv_sector_type sector;
      logic [11:0]    k;      // distance into sector, mirrored in falling sectors
      logic [10:0]    sat;    // clamped to 1.0
      logic [10:0]    val;    // clamped to 1.0
   } hsv_item_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } hsv_qstat_type;

endpackage

@@ design/hsv_to_rgb.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb: HSV to 8-bit RGB pixel converter
// Path: a pixel taken on req is written into the queue, then passes the
//   three arithmetic stages and the result register before it shows on rsp.
// Throughput: one pixel per cycle; a 4-entry queue keeps req open while rsp
//   is stalled, until the queue fills.
// Reset: synchronous, clears queue pointers, queue count and pipeline valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hsv_pkg::hsv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsv_pkg::hsv_rsp_type rsp_data
);
   import hsv_pkg::*;

   hsv_item_type  front_item;
   hsv_item_type  head_item;
   hsv_qstat_type q_stat;
   logic          q_push;
   logic          q_pop;

   // Front: wrap hue, clamp s and v, pick the sector. Pure logic, so a
   // transfer on req lands in the queue on the same edge.
   hsv_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   // Stall only on a full queue; the count is registered, so req_stall
   // does not depend on anything at the rsp side within the cycle.
   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   hsv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   // Back: chroma arithmetic and channel mapping. It freezes as a whole
   // when its result register holds a pixel that rsp has not taken.
   hsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!q_stat.empty),
      .item       (head_item),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // Queue occupancy never passes its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCOUNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   // The back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // A push without a pop leaves something in the queue
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_stat.empty)
      else $error("pushed item lost");

endmodule

@@ design/hsv_front.sv @@
// ----------------------------------------------------------------------------
// hsv_front: hue wrap and sector classification
// Wraps hue into one turn, clamps saturation and brightness, and finds the
// sector and the mirrored offset k inside it.
// ----------------------------------------------------------------------------
module hsv_front (
   input  hsv_pkg::hsv_req_type  req_data,
   output hsv_pkg::hsv_item_type item
);
   import hsv_pkg::*;

   localparam logic signed [16:0] TURN_S     = 17'(HUE_TURN);
   localparam logic signed [16:0] NEG_TURN_S = -17'(HUE_TURN);
   localparam logic signed [16:0] TWO_TURN_S = 17'(2 * HUE_TURN);
   localparam logic [10:0]        ONE_C      = 11'(CHAN_ONE);
   localparam logic [11:0]        SPAN_C     = 12'(HUE_SPAN);

   logic signed [16:0] hue_ext;
   logic signed [16:0] hue_adj;
   logic [14:0]        hue_w;
   logic [14:0]        base;
   logic [14:0]        offs;
   logic [11:0]        f;
   logic               falling;

   always_comb begin
      hue_ext = {req_data.hue[15], req_data.hue};
      priority if (hue_ext < NEG_TURN_S) begin
         hue_adj = hue_ext + TWO_TURN_S;
      end else if (hue_ext < 17'sd0) begin
         hue_adj = hue_ext + TURN_S;
      end else if (hue_ext >= TURN_S) begin
         hue_adj = hue_ext - TURN_S;
      end else begin
         hue_adj = hue_ext;
      end
      hue_w = hue_adj[14:0];

      // boundary values go to the higher sector
      priority if (hue_w >= 15'(5 * HUE_SPAN)) begin
         item.sector = SEC_MR;
         base        = 15'(5 * HUE_SPAN);
         falling     = 1'b1;
      end else if (hue_w >= 15'(4 * HUE_SPAN)) begin
         item.sector = SEC_BM;
         base        = 15'(4 * HUE_SPAN);
         falling     = 1'b0;
      end else if (hue_w >= 15'(3 * HUE_SPAN)) begin
         item.sector = SEC_CB;
         base        = 15'(3 * HUE_SPAN);
         falling     = 1'b1;
      end else if (hue_w >= 15'(2 * HUE_SPAN)) begin
         item.sector = SEC_GC;
         base        = 15'(2 * HUE_SPAN);
         falling     = 1'b0;
      end else if (hue_w >= 15'(HUE_SPAN)) begin
         item.sector = SEC_YG;
         base        = 15'(HUE_SPAN);
         falling     = 1'b1;
      end else begin
         item.sector = SEC_RY;
         base        = 15'd0;
         falling     = 1'b0;
      end

      offs   = hue_w - base;
      f      = offs[11:0];
      item.k = falling ? (SPAN_C - f) : f;

      item.sat = (req_data.saturation > ONE_C) ? ONE_C : req_data.saturation;
      item.val = (req_data.brightness > ONE_C) ? ONE_C : req_data.brightness;
   end

endmodule

@@ design/hsv_queue.sv @@
// ----------------------------------------------------------------------------
// hsv_queue: short FIFO between front and back
// Holds classified pixels so the input side keeps taking transfers while the
// back end is stalled.
// ----------------------------------------------------------------------------
module hsv_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hsv_pkg::hsv_item_type  push_item,
   input  logic                   pop,
   output hsv_pkg::hsv_item_type  head_item,
   output hsv_pkg::hsv_qstat_type stat
);
   import hsv_pkg::*;

   hsv_item_type        mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == QCOUNT_W'(QDEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

@@ design/hsv_back.sv @@
// ----------------------------------------------------------------------------
// hsv_back: channel arithmetic pipeline
// Four stages: chroma terms, products with brightness, scale by 255, then the
// divide by 15 and the sector-to-channel mapping into the result register.
// ----------------------------------------------------------------------------
module hsv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  hsv_pkg::hsv_item_type item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hsv_pkg::hsv_rsp_type  rsp_data
);
   import hsv_pkg::*;

   typedef struct packed {
      hsv_sector_type sector;
      logic [10:0]    val;
      logic [22:0]    sk;     // s * (SPAN - k)
      logic [10:0]    ls;     // ONE - s
   } st1_type;

   typedef struct packed {
      hsv_sector_type sector;
      logic [10:0]    val;
      logic [31:0]    pm;     // v * (ONE*SPAN - s*(SPAN-k))
      logic [20:0]    pl;     // v * (ONE - s)
   } st2_type;

   typedef struct packed {
      hsv_sector_type sector;
      logic [7:0]     hi8;
      logic [7:0]     lo8;
      logic [11:0]    q;      // 255*pm / 2^28, still to be divided by 15
   } st3_type;

   st1_type      s1_ff, s1_in;
   st2_type      s2_ff, s2_in;
   st3_type      s3_ff, s3_in;
   logic         v1_ff, v2_ff, v3_ff, vo_ff;
   hsv_rsp_type  out_ff, out_in;
   logic         adv;

   logic [21:0]  mid_term;
   logic [32:0]  pm_full;
   logic [21:0]  pl_full;
   logic [17:0]  top_sc;
   logic [28:0]  low_sc;
   logic [39:0]  mid_sc;
   logic [24:0]  est_prod;
   logic [7:0]   est;
   logic [11:0]  rem;
   logic [7:0]   mi8;

   // whole pipeline moves unless the result register is held
   assign adv = !vo_ff || !rsp_stall;
   assign pop = adv && item_valid;

   // stage 1
   always_comb begin
      s1_in.sector = item.sector;
      s1_in.val    = item.val;
      s1_in.sk     = 23'(item.sat) * 23'(12'(HUE_SPAN) - item.k);
      s1_in.ls     = 11'(CHAN_ONE) - item.sat;
   end

   // stage 2
   always_comb begin
      mid_term     = 22'(MID_FULL) - s1_ff.sk[21:0];
      pm_full      = 33'(s1_ff.val) * 33'(mid_term);
      pl_full      = 22'(s1_ff.val) * 22'(s1_ff.ls);
      s2_in.sector = s1_ff.sector;
      s2_in.val    = s1_ff.val;
      s2_in.pm     = pm_full[31:0];
      s2_in.pl     = pl_full[20:0];
   end

   // stage 3: scale by 255 and drop the 2^-10, 2^-20 and 2^-28 weights
   always_comb begin
      top_sc       = 18'(s2_ff.val) * 18'(CHAN_MAX);
      low_sc       = 29'(s2_ff.pl) * 29'(CHAN_MAX);
      mid_sc       = 40'(s2_ff.pm) * 40'(CHAN_MAX);
      s3_in.sector = s2_ff.sector;
      s3_in.hi8    = top_sc[17:10];
      s3_in.lo8    = low_sc[27:20];
      s3_in.q      = mid_sc[39:28];
   end

   // stage 4: q / 15 by reciprocal, estimate is at most one low
   always_comb begin
      est_prod = 25'(s3_ff.q) * 25'(DIV_RECIP);
      est      = est_prod[23:16];
      rem      = s3_ff.q - 12'(est) * 12'(DIV_SMALL);
      mi8      = est + 8'(rem >= 12'(DIV_SMALL));
      unique case (s3_ff.sector)
         SEC_RY: begin
            out_in = '{red: s3_ff.hi8, green: mi8, blue: s3_ff.lo8};
         end
         SEC_YG: begin
            out_in = '{red: mi8, green: s3_ff.hi8, blue: s3_ff.lo8};
         end
         SEC_GC: begin
            out_in = '{red: s3_ff.lo8, green: s3_ff.hi8, blue: mi8};
         end
         SEC_CB: begin
            out_in = '{red: s3_ff.lo8, green: mi8, blue: s3_ff.hi8};
         end
         SEC_BM: begin
            out_in = '{red: mi8, green: s3_ff.lo8, blue: s3_ff.hi8};
         end
         SEC_MR: begin
            out_in = '{red: s3_ff.hi8, green: s3_ff.lo8, blue: mi8};
         end
         default: begin
            out_in = '{red: s3_ff.hi8, green: s3_ff.lo8, blue: mi8};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= item_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = out_ff;

endmodule

@@ test/hsv_to_rgb_test.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_test: self-checking bench for the HSV to RGB pixel converter
// Drives directed and random pixels through the valid/stall handshake and
// checks each RGB result against an in-bench integer predictor, in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_test;
   import hsv_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 16;      // time for the block's pipeline to show a stray result, plus margin
   localparam int PHASE_PIXELS = 238;     // four random phases, ~950 pixels
   localparam int REPORT_LIMIT = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   hsv_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   hsv_rsp_type rsp_data;

   // Expected colors, oldest first; one entry per accepted pixel
   hsv_rsp_type pending_rgb[$];
   int          mismatch_count = 0;

   // Idle odds in percent, changed per phase
   int          send_idle_pct;
   int          rsp_stall_pct;

   hsv_to_rgb u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 8-unit clock period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Color predictor. Everything is kept over the common denominator
   // ONE*ONE*SPAN so each channel is one exact integer divide, truncated.
   function automatic hsv_rsp_type predict_rgb(hsv_req_type px);
      int                 h;
      int                 f;
      int                 k;
      hsv_sector_type     sector;
      longint unsigned    s;
      longint unsigned    v;
      longint unsigned    one;
      longint unsigned    sp;
      longint unsigned    den;
      longint unsigned    top;
      longint unsigned    low;
      longint unsigned    mid;
      logic [7:0]         hi8;
      logic [7:0]         mi8;
      logic [7:0]         lo8;
      hsv_rsp_type        rgb;
      // wrap into [0, TURN); % truncates toward zero, so fix negatives
      h = int'(px.hue);
      h = h % HUE_TURN;
      if (h < 0) h += HUE_TURN;
      one = longint'(CHAN_ONE);
      sp  = longint'(HUE_SPAN);
      // clamp both channels at 1.0
      s = (px.saturation > CHAN_ONE) ? one : longint'(px.saturation);
      v = (px.brightness > CHAN_ONE) ? one : longint'(px.brightness);
      sector = hsv_sector_type'(h / HUE_SPAN);
      f = h - (h / HUE_SPAN) * HUE_SPAN;
      // falling middle channel in odd sectors: mirror the offset
      k = sector[0] ? (HUE_SPAN - f) : f;
      den = one * one * sp;
      top = v * one * sp;
      low = top - v * s * sp;
      mid = low + v * s * longint'(k);
      hi8 = 8'((top * 255) / den);
      mi8 = 8'((mid * 255) / den);
      lo8 = 8'((low * 255) / den);
      case (sector)
         SEC_RY: begin rgb.red = hi8; rgb.green = mi8; rgb.blue = lo8; end
         SEC_YG: begin rgb.red = mi8; rgb.green = hi8; rgb.blue = lo8; end
         SEC_GC: begin rgb.red = lo8; rgb.green = hi8; rgb.blue = mi8; end
         SEC_CB: begin rgb.red = lo8; rgb.green = mi8; rgb.blue = hi8; end
         SEC_BM: begin rgb.red = mi8; rgb.green = lo8; rgb.blue = hi8; end
         default: begin rgb.red = hi8; rgb.green = lo8; rgb.blue = mi8; end
      endcase
      return rgb;
   endfunction

   function automatic hsv_req_type make_pixel(int hue, int sat, int val);
      hsv_req_type px;
      px.hue        = hue[15:0];
      px.saturation = sat[10:0];
      px.brightness = val[10:0];
      return px;
   endfunction

   // Receiver side: random stall, updated on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Monitor: sample both channels at the rising edge. A pixel transfer
   // queues its prediction; a result transfer is checked against the oldest.
   always @(posedge clock) begin
      hsv_rsp_type exp_rgb;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_rgb.push_back(predict_rgb(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rgb.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected result r=%0d g=%0d b=%0d",
                           rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end else begin
               exp_rgb = pending_rgb.pop_front();
               if (rsp_data.red !== exp_rgb.red || rsp_data.green !== exp_rgb.green ||
                   rsp_data.blue !== exp_rgb.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("rgb mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
                  end
               end
            end
         end
      end
   end

   // Send one pixel. Called at a falling edge, returns at a falling edge.
   // Random idle cycles go in front; the payload holds until the transfer.
   task automatic send_pixel(hsv_req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Extremes of every field, including all-ones and sign bit of hue
   task automatic test_field_extremes();
      send_pixel(make_pixel(32767, 2047, 2047));
      send_pixel(make_pixel(-32768, 0, 0));
      send_pixel(make_pixel(0, 1024, 1024));
      send_pixel(make_pixel(0, 1025, 0));
      send_pixel(make_pixel(100, 0, 2047));
      send_pixel(make_pixel(1000, 1023, 1023));
      send_pixel(make_pixel(-1, 2047, 1025));
   endtask

   // Negative hue and hue past a whole turn both wrap into one turn
   task automatic test_hue_wrap();
      send_pixel(make_pixel(-HUE_TURN, 1024, 1024));
      send_pixel(make_pixel(HUE_TURN, 1024, 1024));
      send_pixel(make_pixel(HUE_TURN - 1, 1024, 1024));
      send_pixel(make_pixel(-HUE_SPAN, 800, 900));
      send_pixel(make_pixel(2 * HUE_TURN + 77, 512, 1024));
   endtask

   // Exact sector boundaries go to the higher sector; check each edge and
   // the step just below it, plus a mid-sector point in every sector
   task automatic test_sector_edges();
      for (int sec = 1; sec < 6; sec++) begin
         send_pixel(make_pixel(sec * HUE_SPAN, 1024, 1024));
         send_pixel(make_pixel(sec * HUE_SPAN - 1, 1024, 1024));
      end
      for (int sec = 0; sec < 6; sec++) begin
         send_pixel(make_pixel(sec * HUE_SPAN + HUE_SPAN / 2, 700, 1000));
      end
   endtask

   // Channel value: mostly in range, some past 1.0, some on the corners
   function automatic int pick_level();
      int corner[5] = '{0, 1023, 1024, 1025, 2047};
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) return $urandom_range(CHAN_ONE);
      if (sel < 80) return $urandom_range(2047);
      return corner[$urandom_range(4)];
   endfunction

   // Random pixels under one idle setting
   task automatic test_random_pixels(int count, int idle_pct, int stall_pct);
      int hue;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 70) begin
            hue = $urandom_range(65535);
         end else begin
            // near a sector edge, in the base turn or one turn below
            hue = $urandom_range(5) * HUE_SPAN + $urandom_range(4) - 2
                  - $urandom_range(1) * HUE_TURN;
         end
         send_pixel(make_pixel(hue, pick_level(), pick_level()));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_field_extremes();
      test_hue_wrap();
      test_sector_edges();
      test_random_pixels(PHASE_PIXELS, 0, 0);
      test_random_pixels(PHASE_PIXELS, 84, 0);
      test_random_pixels(PHASE_PIXELS, 0, 84);
      test_random_pixels(PHASE_PIXELS, 29, 29);
      req_valid <= 1'b0;

      // drain, then give the pipeline time to show any stray result
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rgb.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
